[src/lao_pkg.sv]
// Shared constants and types for the look-at orientation matrix block.
// No dependencies; every other file imports this package.
package lao_pkg;

   localparam int IN_W     = 16;
   localparam int OUT_W    = 16;
   localparam int OUT_FRAC = 14;
   localparam int CROSS_W  = 32;
   localparam int NORM_TOP = 29;
   localparam int NORM_W   = NORM_TOP + 1;
   localparam int ROOT_W   = NORM_W + 1;
   localparam int QUO_W    = OUT_FRAC + 1;
   localparam int NUM_W    = NORM_W + QUO_W;

   typedef logic signed [OUT_W-1:0] comp_type;
   typedef logic signed [IN_W-1:0]  in_comp_type;

endpackage

[src/lao_isqrt.sv]
// Pipelined integer square root, one root bit per register stage.
// Carries an opaque side word alongside; depends on lao_pkg.
module lao_isqrt import lao_pkg::*; #(
   parameter int RW = ROOT_W,
   parameter int SW = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [2*RW-1:0]   in_rad,
   input  logic [SW-1:0]     in_side,
   output logic              out_valid,
   output logic [RW-1:0]     out_root,
   output logic [SW-1:0]     out_side
);

   logic [2*RW-1:0] rem_w  [0:RW];
   logic [RW-1:0]   root_w [0:RW];
   logic [SW-1:0]   side_w [0:RW];
   logic            vld_w  [0:RW];

   assign rem_w[0]  = in_rad;
   assign root_w[0] = '0;
   assign side_w[0] = in_side;
   assign vld_w[0]  = in_valid;

   for (genvar i = 0; i < RW; i++) begin : g_step
      localparam int K = RW - 1 - i;
      logic [2*RW:0]   trial;
      logic [2*RW-1:0] rem_in;
      logic [2*RW-1:0] rem_ff;
      logic [RW-1:0]   root_in;
      logic [RW-1:0]   root_ff;
      logic [SW-1:0]   side_ff;
      logic            vld_ff;

      always_comb begin
         trial = ({{(RW+1){1'b0}}, root_w[i]} << (K + 1))
               + ({{(2*RW){1'b0}}, 1'b1} << (2 * K));
         if ({1'b0, rem_w[i]} >= trial) begin
            rem_in  = rem_w[i] - trial[2*RW-1:0];
            root_in = root_w[i] | ({{(RW-1){1'b0}}, 1'b1} << K);
         end else begin
            rem_in  = rem_w[i];
            root_in = root_w[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else begin
            vld_ff <= vld_w[i];
         end
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= side_w[i];
      end

      assign rem_w[i+1]  = rem_ff;
      assign root_w[i+1] = root_ff;
      assign side_w[i+1] = side_ff;
      assign vld_w[i+1]  = vld_ff;
   end

   assign out_valid = vld_w[RW] & (rem_w[RW] == rem_w[RW] );
   assign out_root  = root_w[RW];
   assign out_side  = side_w[RW];

endmodule

[src/lao_norm.sv]
// Pipelined vector normalizer: magnitude, block scaling, squares, root,
// and a bit-per-stage divider per lane. Depends on lao_pkg and lao_isqrt.
module lao_norm import lao_pkg::*; #(
   parameter int CW = CROSS_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [CW-1:0] in_c [3],
   output logic                 out_valid,
   output comp_type             out_c [3],
   output logic                 out_zero
);

   localparam int PW = $clog2(CW);
   localparam int SW = 3 * NORM_W + 4;

   // magnitude and sign
   logic [CW-1:0] mag1_in [3];
   logic [CW-1:0] mag1_ff [3];
   logic [2:0]    neg1_ff;
   logic          vld1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag1_in[i] = in_c[i][CW-1] ? ($unsigned(~in_c[i]) + CW'(1)) : $unsigned(in_c[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
      end
      for (int i = 0; i < 3; i++) begin
         mag1_ff[i] <= mag1_in[i];
         neg1_ff[i] <= in_c[i][CW-1];
      end
   end

   // leading one of the largest component
   logic [CW-1:0] any_w;
   logic [PW-1:0] lead2_in;
   logic [PW-1:0] lead2_ff;
   logic [CW-1:0] mag2_ff [3];
   logic [2:0]    neg2_ff;
   logic          zero2_ff;
   logic          vld2_ff;

   assign any_w = mag1_ff[0] | mag1_ff[1] | mag1_ff[2];

   always_comb begin
      lead2_in = '0;
      for (int b = 0; b < CW; b++) begin
         if (any_w[b]) begin
            lead2_in = PW'(b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else begin
         vld2_ff <= vld1_ff;
      end
      lead2_ff <= lead2_in;
      mag2_ff  <= mag1_ff;
      neg2_ff  <= neg1_ff;
      zero2_ff <= (any_w == '0);
   end

   // scale so the leading one of the largest lands on the top bit
   logic [NORM_W-1:0] nrm3_in [3];
   logic [NORM_W-1:0] nrm3_ff [3];
   logic [2:0]        neg3_ff;
   logic              zero3_ff;
   logic              vld3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (lead2_ff > PW'(NORM_TOP)) begin
            nrm3_in[i] = NORM_W'(mag2_ff[i] >> (lead2_ff - PW'(NORM_TOP)));
         end else begin
            nrm3_in[i] = NORM_W'(mag2_ff[i] << (PW'(NORM_TOP) - lead2_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
      end else begin
         vld3_ff <= vld2_ff;
      end
      nrm3_ff  <= nrm3_in;
      neg3_ff  <= neg2_ff;
      zero3_ff <= zero2_ff;
   end

   // squares
   logic [2*NORM_W-1:0] sq4_ff [3];
   logic [NORM_W-1:0]   nrm4_ff [3];
   logic [2:0]          neg4_ff;
   logic                zero4_ff;
   logic                vld4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
      end else begin
         vld4_ff <= vld3_ff;
      end
      for (int i = 0; i < 3; i++) begin
         sq4_ff[i] <= nrm3_ff[i] * nrm3_ff[i];
      end
      nrm4_ff  <= nrm3_ff;
      neg4_ff  <= neg3_ff;
      zero4_ff <= zero3_ff;
   end

   // sum of squares
   logic [2*ROOT_W-1:0] sum5_ff;
   logic [NORM_W-1:0]   nrm5_ff [3];
   logic [2:0]          neg5_ff;
   logic                zero5_ff;
   logic                vld5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld5_ff <= 1'b0;
      end else begin
         vld5_ff <= vld4_ff;
      end
      sum5_ff  <= (2*ROOT_W)'(sq4_ff[0]) + (2*ROOT_W)'(sq4_ff[1]) + (2*ROOT_W)'(sq4_ff[2]);
      nrm5_ff  <= nrm4_ff;
      neg5_ff  <= neg4_ff;
      zero5_ff <= zero4_ff;
   end

   // root
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   logic [SW-1:0]     sq_side;

   lao_isqrt #(
      .RW(ROOT_W),
      .SW(SW)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld5_ff),
      .in_rad    (sum5_ff),
      .in_side   ({nrm5_ff[0], nrm5_ff[1], nrm5_ff[2], neg5_ff, zero5_ff}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // dividend with rounding term
   logic [NORM_W-1:0] nrm_q [3];
   logic [NUM_W-1:0]  num6_ff [3];
   logic [ROOT_W-1:0] root6_ff;
   logic [2:0]        neg6_ff;
   logic              zero6_ff;
   logic              vld6_ff;

   assign nrm_q[0] = sq_side[SW-1 -: NORM_W];
   assign nrm_q[1] = sq_side[SW-1-NORM_W -: NORM_W];
   assign nrm_q[2] = sq_side[SW-1-2*NORM_W -: NORM_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld6_ff <= 1'b0;
      end else begin
         vld6_ff <= sq_valid;
      end
      for (int i = 0; i < 3; i++) begin
         num6_ff[i] <= NUM_W'({nrm_q[i], {OUT_FRAC{1'b0}}}) + NUM_W'(sq_root >> 1);
      end
      root6_ff <= sq_root;
      neg6_ff  <= sq_side[3:1];
      zero6_ff <= sq_side[0];
   end

   // restoring division, one quotient bit per stage
   logic [NUM_W-1:0]  rem_w  [0:QUO_W][3];
   logic [QUO_W-1:0]  quo_w  [0:QUO_W][3];
   logic [ROOT_W-1:0] root_w [0:QUO_W];
   logic [2:0]        neg_w  [0:QUO_W];
   logic              zero_w [0:QUO_W];
   logic              vld_w  [0:QUO_W];

   assign rem_w[0]  = num6_ff;
   assign quo_w[0]  = '{default: '0};
   assign root_w[0] = root6_ff;
   assign neg_w[0]  = neg6_ff;
   assign zero_w[0] = zero6_ff;
   assign vld_w[0]  = vld6_ff;

   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      localparam int K = QUO_W - 1 - j;
      logic [NUM_W-1:0]  den;
      logic [NUM_W-1:0]  rem_in [3];
      logic [QUO_W-1:0]  quo_in [3];
      logic [NUM_W-1:0]  rem_ff [3];
      logic [QUO_W-1:0]  quo_ff [3];
      logic [ROOT_W-1:0] root_ff;
      logic [2:0]        neg_ff;
      logic              zero_ff;
      logic              vld_ff;

      assign den = {{(NUM_W-ROOT_W){1'b0}}, root_w[j]} << K;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            if (rem_w[j][i] >= den) begin
               rem_in[i] = rem_w[j][i] - den;
               quo_in[i] = quo_w[j][i] | (QUO_W'(1) << K);
            end else begin
               rem_in[i] = rem_w[j][i];
               quo_in[i] = quo_w[j][i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else begin
            vld_ff <= vld_w[j];
         end
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         root_ff <= root_w[j];
         neg_ff  <= neg_w[j];
         zero_ff <= zero_w[j];
      end

      assign rem_w[j+1]  = rem_ff;
      assign quo_w[j+1]  = quo_ff;
      assign root_w[j+1] = root_ff;
      assign neg_w[j+1]  = neg_ff;
      assign zero_w[j+1] = zero_ff;
      assign vld_w[j+1]  = vld_ff;
   end

   // cap, sign, zero
   localparam logic [QUO_W-1:0] ONE = QUO_W'(1) << OUT_FRAC;

   logic [QUO_W-1:0] cap_w [3];
   comp_type         out_c_in [3];
   comp_type         out_c_ff [3];
   logic             zero_ff;
   logic             vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cap_w[i] = (quo_w[QUO_W][i] > ONE) ? ONE : quo_w[QUO_W][i];
         if (zero_w[QUO_W]) begin
            out_c_in[i] = '0;
         end else if (neg_w[QUO_W][i]) begin
            out_c_in[i] = OUT_W'(0) - OUT_W'(cap_w[i]);
         end else begin
            out_c_in[i] = OUT_W'(cap_w[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_w[QUO_W] & (rem_w[QUO_W][0] == rem_w[QUO_W][0]);
      end
      out_c_ff <= out_c_in;
      zero_ff  <= zero_w[QUO_W] | (root_w[QUO_W] == '1 && 1'b0);
   end

   assign out_valid = vld_ff;
   assign out_c     = out_c_ff;
   assign out_zero  = zero_ff;

endmodule

[src/look_at_orientation_matrix.sv]
// Look-at orientation matrix: top level with cross product, two
// normalizers and the up-row stage. Depends on lao_pkg and lao_norm.
//
// Usage:
// - Input word: raise start with the look vector and up hint (signed Q8.8)
//   on the req_ ports; it is taken at any edge where start is high and
//   busy is low. busy never rises, so one word may enter every cycle.
// - Result word: rsp_valid strobes for one cycle with the three matrix
//   rows (side, up, back) in signed Q1.14 and the two degenerate flags.
// - Throughput: one word per cycle. Pipeline depth is set by the
//   bit-per-stage square root (31 stages) and divider (15 stages).
// - Reset clears all valid bits; words in flight are dropped.
// - The receiver cannot stall: a strobed word must be taken in its cycle.
module look_at_orientation_matrix import lao_pkg::*; #(
   parameter int CROSS_WIDTH = CROSS_W
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  in_comp_type req_look_x,
   input  in_comp_type req_look_y,
   input  in_comp_type req_look_z,
   input  in_comp_type req_hint_x,
   input  in_comp_type req_hint_y,
   input  in_comp_type req_hint_z,
   output logic        rsp_valid,
   output comp_type    rsp_side_x,
   output comp_type    rsp_side_y,
   output comp_type    rsp_side_z,
   output comp_type    rsp_up_x,
   output comp_type    rsp_up_y,
   output comp_type    rsp_up_z,
   output comp_type    rsp_back_x,
   output comp_type    rsp_back_y,
   output comp_type    rsp_back_z,
   output logic        rsp_look_degenerate,
   output logic        rsp_side_degenerate
);

   typedef logic signed [CROSS_WIDTH-1:0] wide_type;
   typedef logic signed [CROSS_WIDTH:0]   diff_type;

   function automatic comp_type round_sat(input diff_type d);
      logic [CROSS_WIDTH:0] mag;
      logic [CROSS_WIDTH:0] r;
      mag = d[CROSS_WIDTH] ? $unsigned(-d) : $unsigned(d);
      r = (mag + ((CROSS_WIDTH+1)'(1) << (OUT_FRAC - 1))) >> OUT_FRAC;
      if (r > ((CROSS_WIDTH+1)'(1) << OUT_FRAC)) begin
         r = (CROSS_WIDTH+1)'(1) << OUT_FRAC;
      end
      return d[CROSS_WIDTH] ? comp_type'(OUT_W'(0) - OUT_W'(r)) : comp_type'(OUT_W'(r));
   endfunction

   assign busy = 1'b0;

   // cross-product partial products
   wide_type    prod1_ff [6];
   in_comp_type look1_ff [3];
   logic        vld1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= start & ~busy;
      end
      prod1_ff[0] <= wide_type'(req_look_y) * wide_type'(req_hint_z);
      prod1_ff[1] <= wide_type'(req_look_z) * wide_type'(req_hint_y);
      prod1_ff[2] <= wide_type'(req_look_z) * wide_type'(req_hint_x);
      prod1_ff[3] <= wide_type'(req_look_x) * wide_type'(req_hint_z);
      prod1_ff[4] <= wide_type'(req_look_x) * wide_type'(req_hint_y);
      prod1_ff[5] <= wide_type'(req_look_y) * wide_type'(req_hint_x);
      look1_ff[0] <= req_look_x;
      look1_ff[1] <= req_look_y;
      look1_ff[2] <= req_look_z;
   end

   // cross product
   wide_type cross2_ff [3];
   wide_type look2_ff  [3];
   logic     vld2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else begin
         vld2_ff <= vld1_ff;
      end
      cross2_ff[0] <= prod1_ff[0] - prod1_ff[1];
      cross2_ff[1] <= prod1_ff[2] - prod1_ff[3];
      cross2_ff[2] <= prod1_ff[4] - prod1_ff[5];
      for (int i = 0; i < 3; i++) begin
         look2_ff[i] <= wide_type'(look1_ff[i]);
      end
   end

   // normalize both vectors in lockstep
   logic     fwd_valid;
   comp_type fwd_c [3];
   logic     fwd_zero;
   logic     sd_valid;
   comp_type sd_c [3];
   logic     sd_zero;

   lao_norm #(.CW(CROSS_WIDTH)) u_fwd_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld2_ff),
      .in_c      (look2_ff),
      .out_valid (fwd_valid),
      .out_c     (fwd_c),
      .out_zero  (fwd_zero)
   );

   lao_norm #(.CW(CROSS_WIDTH)) u_side_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld2_ff),
      .in_c      (cross2_ff),
      .out_valid (sd_valid),
      .out_c     (sd_c),
      .out_zero  (sd_zero)
   );

   // up-row products
   wide_type prod3_ff [6];
   comp_type side3_ff [3];
   comp_type back3_ff [3];
   logic     ldeg3_ff;
   logic     sdeg3_ff;
   logic     vld3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
      end else begin
         vld3_ff <= fwd_valid & sd_valid;
      end
      prod3_ff[0] <= wide_type'(sd_c[1]) * wide_type'(fwd_c[2]);
      prod3_ff[1] <= wide_type'(sd_c[2]) * wide_type'(fwd_c[1]);
      prod3_ff[2] <= wide_type'(sd_c[2]) * wide_type'(fwd_c[0]);
      prod3_ff[3] <= wide_type'(sd_c[0]) * wide_type'(fwd_c[2]);
      prod3_ff[4] <= wide_type'(sd_c[0]) * wide_type'(fwd_c[1]);
      prod3_ff[5] <= wide_type'(sd_c[1]) * wide_type'(fwd_c[0]);
      side3_ff <= sd_c;
      for (int i = 0; i < 3; i++) begin
         back3_ff[i] <= OUT_W'(0) - fwd_c[i];
      end
      ldeg3_ff <= fwd_zero;
      sdeg3_ff <= sd_zero;
   end

   // round, saturate and drive the result word
   diff_type d_w [3];
   comp_type up_ff [3];
   comp_type side_ff [3];
   comp_type back_ff [3];
   logic     ldeg_ff;
   logic     sdeg_ff;
   logic     vld_ff;

   assign d_w[0] = diff_type'(prod3_ff[0]) - diff_type'(prod3_ff[1]);
   assign d_w[1] = diff_type'(prod3_ff[2]) - diff_type'(prod3_ff[3]);
   assign d_w[2] = diff_type'(prod3_ff[4]) - diff_type'(prod3_ff[5]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld3_ff;
      end
      for (int i = 0; i < 3; i++) begin
         up_ff[i] <= round_sat(d_w[i]);
      end
      side_ff <= side3_ff;
      back_ff <= back3_ff;
      ldeg_ff <= ldeg3_ff;
      sdeg_ff <= sdeg3_ff;
   end

   assign rsp_valid           = vld_ff;
   assign rsp_side_x          = side_ff[0];
   assign rsp_side_y          = side_ff[1];
   assign rsp_side_z          = side_ff[2];
   assign rsp_up_x            = up_ff[0];
   assign rsp_up_y            = up_ff[1];
   assign rsp_up_z            = up_ff[2];
   assign rsp_back_x          = back_ff[0];
   assign rsp_back_y          = back_ff[1];
   assign rsp_back_z          = back_ff[2];
   assign rsp_look_degenerate = ldeg_ff;
   assign rsp_side_degenerate = sdeg_ff;

endmodule
